@@ hdl/bffla_pkg.sv @@
// ----------------------------------------------------------------------------
// bffla_pkg: shared types and constants
// Request/result payloads and table geometry for the best-fit allocator.
// ----------------------------------------------------------------------------
package bffla_pkg;
  localparam int SLOT_COUNT = 32;
  localparam int ADDR_BITS  = 20;
  localparam int SIZE_BITS  = ADDR_BITS + 1;
  localparam int IDX_BITS   = $clog2(SLOT_COUNT);
  localparam int ENT_BITS   = ADDR_BITS + SIZE_BITS;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [SIZE_BITS-1:0] ARENA_MAX = SIZE_BITS'(1) << ADDR_BITS;

  typedef struct packed {
    logic                 cmd;
    logic [SIZE_BITS-1:0] req_size;
    logic [3:0]           align_log2;
    logic [ADDR_BITS-1:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] result_addr;
    logic [1:0]           status;
    logic [SIZE_BITS-1:0] free_total;
  } rsp_t;

  // one table write from the controller to the slot memory
  typedef struct packed {
    logic                 en;
    logic [IDX_BITS-1:0]  idx;
    logic                 valid;
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_BITS-1:0] size;
  } wr_t;
endpackage

@@ hdl/bffla_slot_mem.sv @@
// ----------------------------------------------------------------------------
// bffla_slot_mem: slot table storage
// Start/size memory with registered read plus valid flags in flops.
// ----------------------------------------------------------------------------
module bffla_slot_mem import bffla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 init,
  input  logic [SIZE_BITS-1:0] init_size,
  input  wr_t                  wr,
  input  logic [IDX_BITS-1:0]  rd_idx,
  output logic [ADDR_BITS-1:0] rd_start,
  output logic [SIZE_BITS-1:0] rd_size,
  output logic                 rd_valid,
  output logic [SLOT_COUNT-1:0] valid_vec
);
  logic [ENT_BITS-1:0]   mem [SLOT_COUNT];
  logic [ENT_BITS-1:0]   rd_q;
  logic [SLOT_COUNT-1:0] valid;

  // entry 0 holds the whole arena after reset or an arena write
  always_ff @(posedge clk) begin
    if (rst) begin
      mem[0] <= {ADDR_BITS'(0), ARENA_MAX};
    end else if (init) begin
      mem[0] <= {ADDR_BITS'(0), init_size};
    end else if (wr.en) begin
      mem[wr.idx] <= {wr.start, wr.size};
    end
    rd_q <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= SLOT_COUNT'(1);
    end else if (init) begin
      valid <= SLOT_COUNT'(init_size != '0);
    end else if (wr.en) begin
      valid[wr.idx] <= wr.valid;
    end
  end

  logic [IDX_BITS-1:0] rd_idx_q;
  always_ff @(posedge clk) rd_idx_q <= rd_idx;

  assign rd_start  = rd_q[ENT_BITS-1:SIZE_BITS];
  assign rd_size   = rd_q[SIZE_BITS-1:0];
  assign rd_valid  = valid[rd_idx_q];
  assign valid_vec = valid;
endmodule

@@ hdl/bffla_ctrl.sv @@
// ----------------------------------------------------------------------------
// bffla_ctrl: scan and update sequencer
// Walks the slot table once per request, then writes back up to two entries.
// ----------------------------------------------------------------------------
module bffla_ctrl import bffla_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  req_t                  in_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rsp_t                  out_rsp,
  input  logic [SIZE_BITS-1:0]  arena,
  input  logic                  cfg_init,
  output wr_t                   wr,
  output logic [IDX_BITS-1:0]   rd_idx,
  input  logic [ADDR_BITS-1:0]  rd_start,
  input  logic [SIZE_BITS-1:0]  rd_size,
  input  logic                  rd_valid,
  input  logic [SLOT_COUNT-1:0] valid_vec
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_UPD2 = 3'd5;

  logic [2:0]           state;
  req_t                 req;
  logic [IDX_BITS:0]    cnt;      // issued read index, wide enough for the count
  logic                 rd_live;  // a scan read returns this cycle
  logic [IDX_BITS-1:0]  rd_ptr;   // index of returning data
  logic                 best_ok, prev_ok, next_ok, overlap;
  logic [IDX_BITS-1:0]  best, prev, next;
  logic [SIZE_BITS-1:0] best_size, need;
  logic [ADDR_BITS-1:0] best_start;
  logic [ADDR_BITS-1:0] p_start, n_start;
  logic [SIZE_BITS-1:0] n_size;
  logic [SIZE_BITS-1:0] free_bytes;
  logic                 unused_ok;
  logic [IDX_BITS-1:0]  unused;
  logic [SIZE_BITS+1:0] end_e;
  rsp_t                 rsp;
  logic                 res_pend;

  // first unused entry, from the flag vector
  always_comb begin
    unused_ok = 1'b0;
    unused    = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_vec[i]) begin
        unused_ok = 1'b1;
        unused    = IDX_BITS'(i);
      end
    end
  end

  logic [SIZE_BITS+1:0] align_w;
  logic [SIZE_BITS+1:0] se_w;
  assign align_w = (SIZE_BITS+2)'(1) << req.align_log2;
  assign end_e   = (SIZE_BITS+2)'(req.block_addr) + (SIZE_BITS+2)'(req.req_size);
  assign se_w    = (SIZE_BITS+2)'(rd_start) + (SIZE_BITS+2)'(rd_size);

  // aligned start and end of the chosen slot
  logic [SIZE_BITS+1:0] a_start, a_end, old_end;
  assign a_start = ((SIZE_BITS+2)'(best_start) + align_w - 1) & ~(align_w - 1);
  assign a_end   = a_start + (SIZE_BITS+2)'(req.req_size);
  assign old_end = (SIZE_BITS+2)'(best_start) + (SIZE_BITS+2)'(best_size);

  assign in_ready  = (state == S_IDLE) && !res_pend;
  assign out_valid = res_pend;
  assign out_rsp   = rsp;
  assign rd_idx    = (state == S_RD1) ? prev : (state == S_RD2) ? next : cnt[IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst || cfg_init) begin
      state      <= S_IDLE;
      res_pend   <= 1'b0;
      rd_live    <= 1'b0;
      free_bytes <= rst ? ARENA_MAX : arena;
      wr         <= '0;
    end else begin
      wr.en <= 1'b0;
      if (res_pend && out_ready) res_pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req     <= in_req;
            cnt     <= '0;
            rd_live <= 1'b0;
            best_ok <= 1'b0; prev_ok <= 1'b0; next_ok <= 1'b0; overlap <= 1'b0;
            need    <= SIZE_BITS'((SIZE_BITS+2)'(in_req.req_size)
                       + ((SIZE_BITS+2)'(1) << in_req.align_log2) - 1);
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read a cycle, examine the entry that returns
          rd_live <= cnt < (IDX_BITS+1)'(SLOT_COUNT);
          rd_ptr  <= cnt[IDX_BITS-1:0];
          if (cnt < (IDX_BITS+1)'(SLOT_COUNT)) cnt <= cnt + 1'b1;
          if (rd_live && rd_valid) begin
            if (req.cmd == CMD_ALLOC) begin
              if ({1'b0, rd_size} + (SIZE_BITS+1)'(0) >= {1'b0, need}
                  && (SIZE_BITS+2)'(rd_size) >= (SIZE_BITS+2)'(req.req_size) + align_w - 1
                  && (!best_ok || rd_size < best_size
                      || (rd_size == best_size && rd_start < best_start))) begin
                best_ok <= 1'b1; best <= rd_ptr;
                best_size <= rd_size; best_start <= rd_start;
              end
            end else begin
              if ((SIZE_BITS+2)'(rd_start) < end_e && (SIZE_BITS+2)'(req.block_addr) < se_w)
                overlap <= 1'b1;
              if ((SIZE_BITS+2)'(rd_start) == end_e && !next_ok) begin
                next_ok <= 1'b1; next <= rd_ptr;
              end else if (se_w == (SIZE_BITS+2)'(req.block_addr) && !prev_ok) begin
                prev_ok <= 1'b1; prev <= rd_ptr;
              end
            end
          end
          if (!rd_live && cnt == (IDX_BITS+1)'(SLOT_COUNT)) state <= S_RD1;
        end
        S_RD1: state <= S_RD2;   // prev read issued
        S_RD2: begin             // prev data back, next read issued
          p_start <= rd_start;
          state   <= S_UPD;
        end
        S_UPD: begin
          n_start <= rd_start; n_size <= rd_size;
          rsp.result_addr <= '0;
          rsp.status      <= ST_OK;
          rsp.free_total  <= free_bytes;
          state           <= S_IDLE;
          res_pend        <= 1'b1;
          if (req.cmd == CMD_ALLOC) begin
            if (!best_ok) begin
              rsp.status <= ST_NOFIT;
            end else if (a_end == old_end) begin
              wr <= '{en: 1'b1, idx: best, valid: a_start > (SIZE_BITS+2)'(best_start),
                      start: best_start,
                      size: SIZE_BITS'(a_start - (SIZE_BITS+2)'(best_start))};
              rsp.result_addr <= ADDR_BITS'(a_start);
              rsp.free_total  <= free_bytes - req.req_size;
              free_bytes      <= free_bytes - req.req_size;
            end else if (a_start > (SIZE_BITS+2)'(best_start) && !unused_ok) begin
              rsp.status <= ST_FULL;
            end else begin
              wr <= '{en: 1'b1, idx: best, valid: 1'b1, start: ADDR_BITS'(a_end),
                      size: SIZE_BITS'(old_end - a_end)};
              rsp.result_addr <= ADDR_BITS'(a_start);
              rsp.free_total  <= free_bytes - req.req_size;
              free_bytes      <= free_bytes - req.req_size;
              if (a_start > (SIZE_BITS+2)'(best_start)) state <= S_UPD2;
            end
          end else begin
            if (req.req_size == '0) begin
              // nothing to do
            end else if (end_e > (SIZE_BITS+2)'(arena) || overlap) begin
              rsp.status <= ST_NOFIT;
            end else if (!prev_ok && !next_ok && !unused_ok) begin
              rsp.status <= ST_FULL;
            end else begin
              rsp.free_total <= free_bytes + req.req_size;
              free_bytes     <= free_bytes + req.req_size;
              if (prev_ok && next_ok) begin
                wr <= '{en: 1'b1, idx: prev, valid: 1'b1, start: p_start,
                        size: SIZE_BITS'((SIZE_BITS+2)'(rd_start) + (SIZE_BITS+2)'(rd_size)
                                         - (SIZE_BITS+2)'(p_start))};
                state <= S_UPD2;
              end else if (prev_ok) begin
                wr <= '{en: 1'b1, idx: prev, valid: 1'b1, start: p_start,
                        size: SIZE_BITS'(end_e - (SIZE_BITS+2)'(p_start))};
              end else if (next_ok) begin
                wr <= '{en: 1'b1, idx: next, valid: 1'b1, start: req.block_addr,
                        size: rd_size + req.req_size};
              end else begin
                wr <= '{en: 1'b1, idx: unused, valid: 1'b1, start: req.block_addr,
                        size: req.req_size};
              end
            end
          end
        end
        S_UPD2: begin
          state <= S_IDLE;
          if (req.cmd == CMD_ALLOC) begin
            wr <= '{en: 1'b1, idx: unused, valid: 1'b1, start: best_start,
                    size: SIZE_BITS'(a_start - (SIZE_BITS+2)'(best_start))};
          end else begin
            wr <= '{en: 1'b1, idx: next, valid: 1'b0, start: n_start, size: n_size};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/best_fit_free_list_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator_unit: best-fit arena allocator
// Top level: configuration register, slot memory and sequencer.
// ----------------------------------------------------------------------------
// Each request passes from acceptance to result through the sequencer, which
// reads every one of the 32 slot entries through the single read port of the
// slot memory, then reads the merge neighbours and then decides and writes back
// the first entry; a second entry write, when needed, follows in the cycle after.
// One request is in flight at a time; a new request can be taken in the cycle
// after the previous result has been delivered. Writing the arena size on
// cfg_data reinitializes the table and must only happen while the block is idle.
module best_fit_free_list_allocator_unit import bffla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SIZE_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsp_t                 out_data
);
  logic [SIZE_BITS-1:0]  arena;
  logic                  cfg_init;
  logic [SIZE_BITS-1:0]  cfg_sat;
  wr_t                   wr;
  logic [IDX_BITS-1:0]   rd_idx;
  logic [ADDR_BITS-1:0]  rd_start;
  logic [SIZE_BITS-1:0]  rd_size;
  logic                  rd_valid;
  logic [SLOT_COUNT-1:0] valid_vec;

  assign cfg_ready = 1'b1;
  assign cfg_init  = cfg_valid;
  assign cfg_sat   = (cfg_data > ARENA_MAX) ? ARENA_MAX : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena <= ARENA_MAX;
    end else if (cfg_init) begin
      arena <= cfg_sat;
    end
  end

  bffla_slot_mem u_mem (
    .clk, .rst, .init(cfg_init), .init_size(cfg_sat), .wr, .rd_idx,
    .rd_start, .rd_size, .rd_valid, .valid_vec
  );

  bffla_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_req(in_data), .out_valid, .out_ready,
    .out_rsp(out_data), .arena(cfg_init ? cfg_sat : arena), .cfg_init, .wr,
    .rd_idx, .rd_start, .rd_size, .rd_valid, .valid_vec
  );
endmodule

@@ hdl/bffla_checker.sv @@
// ----------------------------------------------------------------------------
// bffla_checker: port-level checks
// Handshake and result sanity checks bound to the allocator top level.
// ----------------------------------------------------------------------------
module bffla_checker import bffla_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status code");
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.result_addr == '0)
    else $error("address on failed request");
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken during work");
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.free_total <= ARENA_MAX)
    else $error("free count above arena");
endmodule

bind best_fit_free_list_allocator_unit bffla_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: best-fit allocator self-checking bench
// Drives allocate/free requests with random idling and back-pressure, predicts
// every result from a behavioral slot table and compares field by field.
// ----------------------------------------------------------------------------
module testbench;
  import bffla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 400000;
  localparam int     REQ_BITS    = $bits(req_t);

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [SIZE_BITS-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  req_t in_data;
  rsp_t out_data;

  best_fit_free_list_allocator_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predicted allocator state
  logic [SIZE_BITS-1:0] arena;
  logic [ADDR_BITS-1:0] tbl_start [SLOT_COUNT];
  logic [SIZE_BITS-1:0] tbl_size  [SLOT_COUNT];
  logic                 tbl_used  [SLOT_COUNT];
  logic [SIZE_BITS-1:0] bytes_free;

  rsp_t pending_rsp[$];
  int   errors = 0;
  bit   calm = 0;       // no idling near the end
  bit   hold_off = 0;   // long receiver stall request
  longint cycles = 0;

  // live allocations, used to build well-formed frees
  logic [ADDR_BITS-1:0] live_addr[$];
  logic [SIZE_BITS-1:0] live_size[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** best_fit_free_list_allocator_unit: FAILED **");
      $finish;
    end
  end

  function automatic void table_reset(logic [SIZE_BITS-1:0] value);
    arena = (value > ARENA_MAX) ? ARENA_MAX : value;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tbl_start[i] = '0;
      tbl_size[i] = '0;
      tbl_used[i] = 1'b0;
    end
    tbl_size[0] = arena;
    tbl_used[0] = (arena != 0);
    bytes_free = arena;
    live_addr.delete();
    live_size.delete();
  endfunction

  function automatic int first_unused();
    for (int i = 0; i < SLOT_COUNT; i++)
      if (!tbl_used[i]) return i;
    return -1;
  endfunction

  function automatic logic [1:0] predict_alloc(longint size, int lg,
                                               output logic [ADDR_BITS-1:0] addr);
    longint align, need, old, start, fin;
    int best, g;
    align = longint'(1) << lg;
    need = size + align - 1;
    best = -1;
    addr = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!tbl_used[i] || longint'(tbl_size[i]) < need) continue;
      if (best < 0 || tbl_size[i] < tbl_size[best] ||
          (tbl_size[i] == tbl_size[best] && tbl_start[i] < tbl_start[best]))
        best = i;
    end
    if (best < 0) return ST_NOFIT;
    old = tbl_start[best];
    start = (old + align - 1) & ~(align - 1);
    fin = start + size;
    if (fin == old + longint'(tbl_size[best])) begin
      if (start > old) tbl_size[best] = SIZE_BITS'(start - old);
      else tbl_used[best] = 1'b0;
    end else begin
      if (start > old) begin
        g = first_unused();
        if (g < 0) return ST_FULL;
        tbl_start[g] = ADDR_BITS'(old);
        tbl_size[g] = SIZE_BITS'(start - old);
        tbl_used[g] = 1'b1;
      end
      tbl_size[best] = SIZE_BITS'(longint'(tbl_size[best]) - (fin - old));
      tbl_start[best] = ADDR_BITS'(fin);
    end
    bytes_free = SIZE_BITS'(bytes_free - size);
    addr = ADDR_BITS'(start);
    return ST_OK;
  endfunction

  function automatic logic [1:0] predict_free(longint a, longint s);
    longint e, ss, se;
    int lo, hi, u;
    e = a + s;
    lo = -1;
    hi = -1;
    if (s == 0) return ST_OK;
    if (e > longint'(arena)) return ST_NOFIT;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!tbl_used[i]) continue;
      ss = tbl_start[i];
      se = ss + tbl_size[i];
      if (ss < e && a < se) return ST_NOFIT;
      if (ss == e && hi < 0) hi = i;
      else if (se == a && lo < 0) lo = i;
    end
    if (lo >= 0 && hi >= 0) begin
      tbl_size[lo] = SIZE_BITS'(longint'(tbl_start[hi]) + tbl_size[hi] - tbl_start[lo]);
      tbl_used[hi] = 1'b0;
    end else if (lo >= 0) begin
      tbl_size[lo] = SIZE_BITS'(e - tbl_start[lo]);
    end else if (hi >= 0) begin
      tbl_size[hi] = SIZE_BITS'(tbl_size[hi] + s);
      tbl_start[hi] = ADDR_BITS'(a);
    end else begin
      u = first_unused();
      if (u < 0) return ST_FULL;
      tbl_start[u] = ADDR_BITS'(a);
      tbl_size[u] = SIZE_BITS'(s);
      tbl_used[u] = 1'b1;
    end
    bytes_free = SIZE_BITS'(bytes_free + s);
    return ST_OK;
  endfunction

  function automatic rsp_t predict_result(req_t r);
    rsp_t p;
    logic [ADDR_BITS-1:0] a;
    a = '0;
    if (r.cmd == CMD_ALLOC) begin
      p.status = predict_alloc(r.req_size, r.align_log2, a);
      if (p.status == ST_OK && r.req_size != 0) begin
        live_addr.push_back(a);
        live_size.push_back(r.req_size);
      end
    end else begin
      p.status = predict_free(r.block_addr, r.req_size);
    end
    p.result_addr = (p.status == ST_OK) ? a : '0;
    p.free_total = bytes_free;
    return p;
  endfunction

  // drop valid only when the sender actually idles
  task automatic idle_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_arena(logic [SIZE_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    table_reset(value);
  endtask

  // send one request; optional typed expectation checked against prediction
  task automatic send_request(req_t r, bit typed = 0, rsp_t typed_rsp = '0);
    rsp_t p;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    p = predict_result(r);
    if (typed && p !== typed_rsp) begin
      $display("%0t typed row mismatch: expected %p predicted %p", $time, typed_rsp, p);
      errors++;
    end
    pending_rsp.push_back(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t unexpected result %p", $time, out_data);
          errors++;
        end else begin
          rsp_t e;
          e = pending_rsp.pop_front();
          if (out_data.result_addr !== e.result_addr)
            $display("%0t result_addr expected %h actual %h", $time,
                     e.result_addr, out_data.result_addr);
          if (out_data.status !== e.status)
            $display("%0t status expected %0d actual %0d", $time, e.status, out_data.status);
          if (out_data.free_total !== e.free_total)
            $display("%0t free_total expected %0d actual %0d", $time,
                     e.free_total, out_data.free_total);
          if (out_data !== e) errors++;
        end
      end
      out_ready <= calm ? 1'b1 : (hold_off ? 1'b0 : ($urandom_range(0, 4) != 0));
    end
  end

  // the long hold-off, counted here; lands in the random phases
  initial begin
    wait (!rst);
    repeat (15000) @(posedge clk);
    hold_off = 1;
    repeat (600) @(posedge clk);
    hold_off = 0;
  end

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t e;
  } row_t;

  function automatic req_t mk(logic c, int sz, int lg, int addr);
    req_t r;
    r.cmd = c;
    r.req_size = SIZE_BITS'(sz);
    r.align_log2 = 4'(lg);
    r.block_addr = ADDR_BITS'(addr);
    return r;
  endfunction

  function automatic rsp_t rs(int a, logic [1:0] st, int ft);
    rsp_t p;
    p.result_addr = ADDR_BITS'(a);
    p.status = st;
    p.free_total = SIZE_BITS'(ft);
    return p;
  endfunction

  task automatic random_request(int lg_max);
    req_t r;
    int k;
    k = $urandom_range(0, 9);
    r = mk(CMD_ALLOC, 0, 0, 0);
    r.align_log2 = 4'($urandom_range(0, lg_max));
    if (k < 5) begin
      r.req_size = SIZE_BITS'($urandom_range(0, 3) == 0 ? $urandom_range(0, 4096)
                                                        : $urandom_range(1, 200));
      r.block_addr = ADDR_BITS'($urandom);
    end else if (k < 9 && live_addr.size() != 0) begin
      int j;
      j = $urandom_range(0, live_addr.size() - 1);
      r.cmd = CMD_FREE;
      r.block_addr = live_addr[j];
      r.req_size = live_size[j];
      if ($urandom_range(0, 5) == 0) begin
        // free only a piece of the block
        r.req_size = SIZE_BITS'($urandom_range(1, live_size[j]));
      end
      live_addr.delete(j);
      live_size.delete(j);
    end else begin
      r = req_t'(REQ_BITS'({$urandom, $urandom}));
      if ($urandom_range(0, 1)) r.req_size = SIZE_BITS'($urandom_range(0, 3000));
    end
    send_request(r);
    idle_gap();
  endtask

  initial begin
    row_t rows[$];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    table_reset(ARENA_MAX);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows on the reset arena
    rows.push_back('{mk(CMD_ALLOC, 0, 0, 0), 1, rs(0, ST_OK, 1048576)});
    rows.push_back('{mk(CMD_ALLOC, 1048577, 0, 0), 1, rs(0, ST_NOFIT, 1048576)});
    rows.push_back('{mk(CMD_ALLOC, 100, 0, 0), 1, rs(0, ST_OK, 1048476)});
    rows.push_back('{mk(CMD_ALLOC, 64, 12, 0), 0, '0});      // alignment gap
    rows.push_back('{mk(CMD_ALLOC, 16, 15, 0), 0, '0});      // large alignment
    rows.push_back('{mk(CMD_FREE, 0, 0, 5), 0, '0});         // zero-byte free
    rows.push_back('{mk(CMD_FREE, 10, 0, 1048575), 0, '0});  // past arena
    rows.push_back('{mk(CMD_FREE, 10, 0, 200), 0, '0});      // overlaps free
    rows.push_back('{mk(CMD_FREE, 100, 0, 0), 0, '0});       // merge above
    rows.push_back('{mk(CMD_FREE, 64, 0, 4096), 0, '0});     // merge both
    rows.push_back('{mk(CMD_FREE, 16, 0, 0), 0, '0});        // fully free rejected
    foreach (rows[i]) begin
      send_request(rows[i].r, rows[i].typed, rows[i].e);
      idle_gap();
    end
    drain();

    // small arena: exact fit, alignment gap, table full
    write_arena(SIZE_BITS'(128));
    send_request(mk(CMD_ALLOC, 128, 0, 0), 1, rs(0, ST_OK, 0));
    send_request(mk(CMD_ALLOC, 1, 0, 0), 1, rs(0, ST_NOFIT, 0));
    send_request(mk(CMD_FREE, 8, 0, 124), 1, rs(0, ST_NOFIT, 0));
    for (int i = 0; i < 34; i++) send_request(mk(CMD_FREE, 1, 0, 2 * i));
    send_request(mk(CMD_ALLOC, 1, 1, 0));
    drain();
    write_arena(SIZE_BITS'(24));
    send_request(mk(CMD_ALLOC, 1, 0, 0));
    send_request(mk(CMD_ALLOC, 8, 4, 0));  // leading alignment gap kept as slot
    drain();
    write_arena(SIZE_BITS'(0));
    send_request(mk(CMD_ALLOC, 0, 0, 0), 1, rs(0, ST_NOFIT, 0));
    send_request(mk(CMD_FREE, 1, 0, 0), 1, rs(0, ST_NOFIT, 0));
    drain();
    write_arena(SIZE_BITS'(2097151));
    send_request(mk(CMD_ALLOC, 1048576, 0, 0), 1, rs(0, ST_OK, 0));
    drain();

    // random phases over several arena sizes; sender bursts to fill the block
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_arena(SIZE_BITS'(1));
        1: write_arena(SIZE_BITS'(4096));
        2: write_arena(SIZE_BITS'($urandom_range(2, 1048576)));
        3: write_arena(SIZE_BITS'(2000));
        default: write_arena(ARENA_MAX);
      endcase
      for (int n = 0; n < 260; n++) begin
        if (ph == 4 && n > 200) calm = 1;
        random_request(ph == 0 ? 1 : 15);
      end
      drain();
    end
    calm = 1;
    drain();
    if (errors == 0)
      $display("** best_fit_free_list_allocator_unit: PASSED **");
    else
      $display("** best_fit_free_list_allocator_unit: FAILED **");
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/bffla_pkg.sv
hdl/bffla_slot_mem.sv
hdl/bffla_ctrl.sv
hdl/best_fit_free_list_allocator_unit.sv
hdl/bffla_checker.sv
tb/sv/testbench.sv
